### sv/ohm_pkg.sv
`default_nettype none

package ohm_pkg;

   // Field widths of the transfer payloads and the register file.
   localparam int SAMPLE_W = 10;
   localparam int COUNT_W = 8;
   localparam int CHANNEL_W = 2;
   localparam int FAULT_W = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 10;
   localparam int BUTTON_COUNT = 3;

   localparam int NUM_CHANNELS_DEFAULT = 3;

   // Register reset values.
   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd1023;
   localparam logic [COUNT_W-1:0] TRIP_LIMIT_RESET = 8'd10;
   localparam logic [COUNT_W-1:0] HOLD_COUNT_RESET = 8'd100;
   localparam logic PROTECTION_RESET = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD_DOWN = 3'd0,
      CSR_THRESHOLD_UP = 3'd1,
      CSR_THRESHOLD_MID = 3'd2,
      CSR_TRIP_COUNT_LIMIT = 3'd3,
      CSR_HOLD_COUNT = 3'd4,
      CSR_PROTECTION_ENABLE = 3'd5
   } csr_index_type;

   typedef enum logic [FAULT_W-1:0] {
      FAULT_NONE = 2'd0,
      FAULT_OVERCURRENT = 2'd1,
      FAULT_EMERGENCY = 2'd2
   } fault_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] threshold_down;
      logic [SAMPLE_W-1:0] threshold_up;
      logic [SAMPLE_W-1:0] threshold_mid;
      logic [COUNT_W-1:0] trip_count_limit;
      logic [COUNT_W-1:0] hold_count;
      logic protection_enable;
   } ohm_cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] current_sample;
      logic start_button;
      logic measure_button;
      logic stop_button;
   } ohm_item_type;

   typedef struct packed {
      logic start_held;
      logic measure_held;
      logic [FAULT_W-1:0] fault;
      logic [CHANNEL_W-1:0] fault_channel;
      logic [CHANNEL_W-1:0] sample_channel;
   } ohm_result_type;

endpackage

`default_nettype wire

### sv/ohm_if.sv
`default_nettype none

interface ohm_req_if;
   import ohm_pkg::*;

   logic valid;
   logic ready;
   logic [SAMPLE_W-1:0] current_sample;
   logic start_button;
   logic measure_button;
   logic stop_button;

   modport source (
      output valid, current_sample, start_button, measure_button, stop_button,
      input ready
   );
   modport sink (
      input valid, current_sample, start_button, measure_button, stop_button,
      output ready
   );
endinterface

interface ohm_rsp_if;
   import ohm_pkg::*;

   logic valid;
   logic ready;
   logic start_held;
   logic measure_held;
   logic [FAULT_W-1:0] fault;
   logic [CHANNEL_W-1:0] fault_channel;
   logic [CHANNEL_W-1:0] sample_channel;

   modport source (
      output valid, start_held, measure_held, fault, fault_channel, sample_channel,
      input ready
   );
   modport sink (
      input valid, start_held, measure_held, fault, fault_channel, sample_channel,
      output ready
   );
endinterface

`default_nettype wire

### sv/ohm_csr.sv
`default_nettype none

module ohm_csr (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_wr_en,
   input wire logic [ohm_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [ohm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output ohm_pkg::ohm_cfg_type cfg
);
   import ohm_pkg::*;

   ohm_cfg_type cfg_ff;
   ohm_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_THRESHOLD_DOWN: cfg_in.threshold_down = csr_wdata[SAMPLE_W-1:0];
            CSR_THRESHOLD_UP: cfg_in.threshold_up = csr_wdata[SAMPLE_W-1:0];
            CSR_THRESHOLD_MID: cfg_in.threshold_mid = csr_wdata[SAMPLE_W-1:0];
            CSR_TRIP_COUNT_LIMIT: cfg_in.trip_count_limit = csr_wdata[COUNT_W-1:0];
            CSR_HOLD_COUNT: cfg_in.hold_count = csr_wdata[COUNT_W-1:0];
            CSR_PROTECTION_ENABLE: cfg_in.protection_enable = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_down <= THRESHOLD_RESET;
         cfg_ff.threshold_up <= THRESHOLD_RESET;
         cfg_ff.threshold_mid <= THRESHOLD_RESET;
         cfg_ff.trip_count_limit <= TRIP_LIMIT_RESET;
         cfg_ff.hold_count <= HOLD_COUNT_RESET;
         cfg_ff.protection_enable <= PROTECTION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### sv/ohm_core.sv
`default_nettype none

module ohm_core #(
   parameter int NUM_CHANNELS = ohm_pkg::NUM_CHANNELS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire ohm_pkg::ohm_cfg_type cfg,
   input wire logic step,
   input wire ohm_pkg::ohm_item_type item,
   output ohm_pkg::ohm_result_type result
);
   import ohm_pkg::*;

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int EXT_W = CH_W + CHANNEL_W;
   localparam int STOP_IDX = 2;

   logic [CH_W-1:0] channel_ff, channel_in;
   logic [CH_W-1:0] tripped_ff, tripped_in;
   logic [COUNT_W-1:0] trip_cnt_ff [NUM_CHANNELS];
   logic [COUNT_W-1:0] trip_cnt_in [NUM_CHANNELS];
   logic [COUNT_W-1:0] btn_cnt_ff [BUTTON_COUNT];
   logic [COUNT_W-1:0] btn_cnt_in [BUTTON_COUNT];
   fault_type fault_ff, fault_in;

   logic [CH_W-1:0] ch_sel;
   logic [CH_W-1:0] ch_rot;
   logic [CH_W:0] ch_plus;
   logic [SAMPLE_W-1:0] threshold;
   logic [BUTTON_COUNT-1:0] pressed;
   logic tripped;
   logic [EXT_W-1:0] tripped_ext;
   logic [EXT_W-1:0] channel_ext;

   // A channel index out of range falls back to channel zero.
   assign ch_sel = ({1'b0, channel_ff} < (CH_W+1)'(NUM_CHANNELS)) ? channel_ff : '0;
   assign ch_plus = {1'b0, ch_sel} + (CH_W+1)'(1);
   assign ch_rot = (ch_plus < (CH_W+1)'(NUM_CHANNELS)) ? ch_plus[CH_W-1:0] : '0;

   // Channels past the second one share the middle threshold.
   always_comb begin
      if (ch_sel == '0) begin
         threshold = cfg.threshold_down;
      end else if (ch_sel == CH_W'(1)) begin
         threshold = cfg.threshold_up;
      end else begin
         threshold = cfg.threshold_mid;
      end
   end

   assign pressed = {item.stop_button, item.measure_button, item.start_button};

   always_comb begin
      channel_in = channel_ff;
      tripped_in = tripped_ff;
      fault_in = fault_ff;
      trip_cnt_in = trip_cnt_ff;
      btn_cnt_in = btn_cnt_ff;
      tripped = 1'b0;
      if (fault_ff == FAULT_NONE) begin
         if (cfg.protection_enable) begin
            if (item.current_sample > threshold) begin
               if (trip_cnt_ff[ch_sel] < cfg.trip_count_limit) begin
                  trip_cnt_in[ch_sel] = trip_cnt_ff[ch_sel] + COUNT_W'(1);
               end else begin
                  fault_in = FAULT_OVERCURRENT;
                  tripped_in = ch_sel;
                  tripped = 1'b1;
               end
            end else begin
               trip_cnt_in[ch_sel] = '0;
            end
            if (!tripped) begin
               channel_in = ch_rot;
            end
         end
         if (!tripped) begin
            for (int b = 0; b < BUTTON_COUNT; b++) begin
               if (pressed[b]) begin
                  if (btn_cnt_ff[b] < cfg.hold_count) begin
                     btn_cnt_in[b] = btn_cnt_ff[b] + COUNT_W'(1);
                  end else if (b == STOP_IDX) begin
                     fault_in = FAULT_EMERGENCY;
                  end
               end else begin
                  btn_cnt_in[b] = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= '0;
         tripped_ff <= '0;
         fault_ff <= FAULT_NONE;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            trip_cnt_ff[c] <= '0;
         end
         for (int b = 0; b < BUTTON_COUNT; b++) begin
            btn_cnt_ff[b] <= '0;
         end
      end else if (step) begin
         channel_ff <= channel_in;
         tripped_ff <= tripped_in;
         fault_ff <= fault_in;
         trip_cnt_ff <= trip_cnt_in;
         btn_cnt_ff <= btn_cnt_in;
      end
   end

   assign tripped_ext = EXT_W'(tripped_in);
   assign channel_ext = EXT_W'(channel_in);

   always_comb begin
      result.start_held = (btn_cnt_in[0] >= cfg.hold_count);
      result.measure_held = (btn_cnt_in[1] >= cfg.hold_count);
      result.fault = FAULT_W'(fault_in);
      result.fault_channel = (fault_in == FAULT_OVERCURRENT) ?
                             tripped_ext[CHANNEL_W-1:0] : '0;
      result.sample_channel = channel_ext[CHANNEL_W-1:0];
   end

endmodule

`default_nettype wire

### sv/overcurrent_and_button_hold_monitor.sv
// Overcurrent and button-hold monitor.
//
// Each transfer on req_if is one sampling tick: the current code of the
// channel named by the last sample_channel, plus the levels of the start,
// measure and stop buttons. Each tick yields exactly one transfer on rsp_if
// with the held flags, the latched fault code, the tripped channel and the
// channel whose sample the next tick should carry.
// The csr_ port writes the thresholds, the trip limit, the hold count and
// the protection enable; write only while no tick is in flight.
// A request transfer lands in the input register; once the output register
// can load, the state update and result are computed in a single pass into
// the output register, which offers the response. Throughput is one tick per
// cycle while the receiver takes every result, set by the read-modify-write
// of the channel, trip and button counters within each single pass.
// Synchronous reset clears all counters and the fault, selects channel zero
// and loads the register reset values. When the receiver stalls, the output
// register holds its result, the input register fills, and req_if.ready drops
// only when both are occupied and the receiver is not taking the result.
// Once a fault latches, later ticks report the frozen state until reset.
`default_nettype none

module overcurrent_and_button_hold_monitor #(
   parameter int NUM_CHANNELS = ohm_pkg::NUM_CHANNELS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   ohm_req_if.sink req_if,
   ohm_rsp_if.source rsp_if,
   input wire logic csr_wr_en,
   input wire logic [ohm_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [ohm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ohm_pkg::*;

   ohm_cfg_type cfg;

   // Input register stage.
   logic s1_valid_ff, s1_valid_in;
   ohm_item_type s1_item_ff;

   // Output register stage.
   logic out_valid_ff, out_valid_in;
   ohm_result_type out_result_ff;

   ohm_result_type core_result;
   logic take;
   logic step;
   logic req_xfer;

   // The output register can load whenever it is empty or being drained.
   assign take = !out_valid_ff || rsp_if.ready;
   assign step = s1_valid_ff && take;
   assign req_if.ready = !s1_valid_ff || take;
   assign req_xfer = req_if.valid && req_if.ready;

   always_comb begin
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (take) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      out_valid_in = take ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff.current_sample <= req_if.current_sample;
         s1_item_ff.start_button <= req_if.start_button;
         s1_item_ff.measure_button <= req_if.measure_button;
         s1_item_ff.stop_button <= req_if.stop_button;
      end
      if (step) begin
         out_result_ff <= core_result;
      end
   end

   ohm_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg(cfg)
   );

   // The monitor state advances exactly when a tick moves into the output
   // register, so ticks are applied in order and once each.
   ohm_core #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .step(step),
      .item(s1_item_ff),
      .result(core_result)
   );

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.start_held = out_result_ff.start_held;
   assign rsp_if.measure_held = out_result_ff.measure_held;
   assign rsp_if.fault = out_result_ff.fault;
   assign rsp_if.fault_channel = out_result_ff.fault_channel;
   assign rsp_if.sample_channel = out_result_ff.sample_channel;

endmodule

`default_nettype wire

### sim/overcurrent_and_button_hold_monitor_tb.sv
`default_nettype none

module overcurrent_and_button_hold_monitor_tb;
   import ohm_pkg::*;

   // The block is built with its default channel count, so the expected
   // results are worked out for the same number of channels.
   localparam int CHANNELS = NUM_CHANNELS_DEFAULT;

   // Positions of the buttons in the hold counters.
   localparam int START_SLOT = 0;
   localparam int MEASURE_SLOT = 1;
   localparam int STOP_SLOT = 2;

   // Register indexes past the last register. Writes to them must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int RANDOM_PHASES = 8;
   localparam int TICKS_PER_PHASE = 142;
   localparam int HOLD_OFF_CYCLES = 48;
   localparam int SETTLE_CYCLES = 4;
   localparam int RUN_LIMIT = 400000;
   localparam int PRINT_CAP = 40;

   // The four ways the run can end. Only one fault can latch per run, since
   // reset is applied once, so the ending is picked at random.
   typedef enum int {
      END_TRIP_AT_ONCE,
      END_TRIP_AFTER_RUN,
      END_STOP_AT_ONCE,
      END_STOP_AFTER_HOLD
   } ending_type;

   // One line of the directed script: either a register write or a tick,
   // optionally with the status it must produce typed in by hand.
   typedef struct {
      bit is_write;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0] reg_data;
      ohm_item_type tick;
      bit has_status;
      ohm_result_type status;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ohm_req_if req_ch ();
   ohm_rsp_if rsp_ch ();

   overcurrent_and_button_hold_monitor i_dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Mirror of the monitor: its registers and state, updated once per
   // accepted tick in the order in which the block accepts them.
   ohm_cfg_type mon_cfg;
   logic [CHANNEL_W-1:0] mon_channel;
   logic [COUNT_W-1:0] mon_run [CHANNELS];
   logic [COUNT_W-1:0] mon_press [BUTTON_COUNT];
   fault_type mon_fault;
   logic [CHANNEL_W-1:0] mon_trip_channel;

   // Status words still owed by the block, oldest first.
   ohm_result_type pending_status [$];
   script_row_type script [$];
   int unsigned mismatch_count = 0;

   // Knobs shared between the stimulus and the response side.
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   bit hold_off_request = 1'b0;

   // Shapes of the random traffic: channels that see long overcurrent runs
   // and buttons that are being held down.
   logic [CHANNELS-1:0] hot_channels = '0;
   logic [BUTTON_COUNT-1:0] held_buttons = '0;

   function automatic logic [SAMPLE_W-1:0] threshold_for(input logic [CHANNEL_W-1:0] ch);
      case (ch)
         2'd0: return mon_cfg.threshold_down;
         2'd1: return mon_cfg.threshold_up;
         default: return mon_cfg.threshold_mid;
      endcase
   endfunction

   function automatic void clear_monitor();
      int i;
      mon_cfg.threshold_down = THRESHOLD_RESET;
      mon_cfg.threshold_up = THRESHOLD_RESET;
      mon_cfg.threshold_mid = THRESHOLD_RESET;
      mon_cfg.trip_count_limit = TRIP_LIMIT_RESET;
      mon_cfg.hold_count = HOLD_COUNT_RESET;
      mon_cfg.protection_enable = PROTECTION_RESET;
      mon_channel = '0;
      for (i = 0; i < CHANNELS; i++) mon_run[i] = '0;
      for (i = 0; i < BUTTON_COUNT; i++) mon_press[i] = '0;
      mon_fault = FAULT_NONE;
      mon_trip_channel = '0;
   endfunction

   // Register writes land in the mirror even after a fault has latched.
   // Only the bits that the register holds are kept.
   function automatic void store_reg(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_THRESHOLD_DOWN: mon_cfg.threshold_down = data;
         CSR_THRESHOLD_UP: mon_cfg.threshold_up = data;
         CSR_THRESHOLD_MID: mon_cfg.threshold_mid = data;
         CSR_TRIP_COUNT_LIMIT: mon_cfg.trip_count_limit = data[COUNT_W-1:0];
         CSR_HOLD_COUNT: mon_cfg.hold_count = data[COUNT_W-1:0];
         CSR_PROTECTION_ENABLE: mon_cfg.protection_enable = data[0];
         default: ;
      endcase
   endfunction

   // Advances the mirror by one sampling tick and returns the status word the
   // block must report for it. The overcurrent check runs first; a trip
   // freezes the channel and skips the button counters for that tick.
   function automatic ohm_result_type monitor_tick(input ohm_item_type it);
      ohm_result_type st;
      logic [CHANNEL_W-1:0] ch;
      logic [BUTTON_COUNT-1:0] pressed;
      bit tripped;
      int b;
      tripped = 1'b0;
      pressed = '0;
      pressed[START_SLOT] = it.start_button;
      pressed[MEASURE_SLOT] = it.measure_button;
      pressed[STOP_SLOT] = it.stop_button;
      if (mon_fault == FAULT_NONE) begin
         ch = (mon_channel >= CHANNELS) ? '0 : mon_channel;
         if (mon_cfg.protection_enable) begin
            if (it.current_sample > threshold_for(ch)) begin
               if (mon_run[ch] < mon_cfg.trip_count_limit) begin
                  mon_run[ch] = mon_run[ch] + 1'b1;
               end else begin
                  mon_fault = FAULT_OVERCURRENT;
                  mon_trip_channel = ch;
                  tripped = 1'b1;
               end
            end else begin
               mon_run[ch] = '0;
            end
            if (!tripped) mon_channel = (ch == CHANNELS - 1) ? '0 : ch + 1'b1;
         end
         if (!tripped) begin
            for (b = 0; b < BUTTON_COUNT; b++) begin
               if (!pressed[b]) begin
                  mon_press[b] = '0;
               end else if (mon_press[b] < mon_cfg.hold_count) begin
                  mon_press[b] = mon_press[b] + 1'b1;
               end else if (b == STOP_SLOT) begin
                  // The stop button was already held long enough.
                  mon_fault = FAULT_EMERGENCY;
               end
            end
         end
      end
      st.start_held = mon_press[START_SLOT] >= mon_cfg.hold_count;
      st.measure_held = mon_press[MEASURE_SLOT] >= mon_cfg.hold_count;
      st.fault = mon_fault;
      st.fault_channel = (mon_fault == FAULT_OVERCURRENT) ? mon_trip_channel : '0;
      st.sample_channel = mon_channel;
      return st;
   endfunction

   // Random tick for the long part of the run. The traffic is shaped so that
   // runs and holds come right up to their limits, but the tick is bent back
   // whenever it would latch a fault, since a fault ends all useful checking.
   function automatic ohm_item_type shaped_tick();
      ohm_item_type it;
      logic [SAMPLE_W-1:0] thr;
      int unsigned pick;
      int near;
      int b;
      logic [BUTTON_COUNT-1:0] press;
      thr = threshold_for(mon_channel);
      pick = $urandom_range(0, 99);
      if (hot_channels[mon_channel] && thr != '1 && pick < 85) begin
         it.current_sample = SAMPLE_W'($urandom_range(int'(thr) + 1, 1023));
      end else if (pick < 15) begin
         it.current_sample = '0;
      end else if (pick < 30) begin
         it.current_sample = '1;
      end else if (pick < 55) begin
         near = int'(thr) + int'($urandom_range(0, 4)) - 2;
         if (near < 0) near = 0;
         if (near > 1023) near = 1023;
         it.current_sample = SAMPLE_W'(near);
      end else begin
         it.current_sample = SAMPLE_W'($urandom_range(0, 1023));
      end
      if (mon_cfg.protection_enable && it.current_sample > thr &&
          mon_run[mon_channel] >= mon_cfg.trip_count_limit) begin
         it.current_sample = SAMPLE_W'($urandom_range(0, int'(thr)));
      end
      for (b = 0; b < BUTTON_COUNT; b++) begin
         press[b] = held_buttons[b] ? ($urandom_range(0, 99) < 90)
                                    : ($urandom_range(0, 99) < 10);
      end
      if (mon_press[STOP_SLOT] >= mon_cfg.hold_count) press[STOP_SLOT] = 1'b0;
      it.start_button = press[START_SLOT];
      it.measure_button = press[MEASURE_SLOT];
      it.stop_button = press[STOP_SLOT];
      return it;
   endfunction

   function automatic void write_row(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      script_row_type row;
      row = '{default: '0};
      row.is_write = 1'b1;
      row.reg_index = idx;
      row.reg_data = data;
      script.push_back(row);
   endfunction

   function automatic void tick_row(input logic [SAMPLE_W-1:0] sample, input logic start,
                                    input logic measure, input logic stop,
                                    input bit has_status = 1'b0,
                                    input ohm_result_type status = '0);
      script_row_type row;
      row = '{default: '0};
      row.tick.current_sample = sample;
      row.tick.start_button = start;
      row.tick.measure_button = measure;
      row.tick.stop_button = stop;
      row.has_status = has_status;
      row.status = status;
      script.push_back(row);
   endfunction

   // Offers one tick, possibly after an idle gap, and waits for the
   // transfer. The mirror is advanced at the edge that accepts it. A status
   // typed into the script takes the place of the computed one.
   task automatic send_tick(input ohm_item_type it, input bit has_status = 1'b0,
                            input ohm_result_type status = '0);
      ohm_result_type computed;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.current_sample <= it.current_sample;
      req_ch.start_button <= it.start_button;
      req_ch.measure_button <= it.measure_button;
      req_ch.stop_button <= it.stop_button;
      do @(posedge clock); while (!req_ch.ready);
      computed = monitor_tick(it);
      pending_status.push_back(has_status ? status : computed);
   endtask

   // Stops offering ticks and waits until every owed status word has come
   // back, then lets the clock run on so that the block settles.
   task automatic drain_block();
      req_ch.valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Registers are only written while the block has nothing in flight.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      drain_block();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      store_reg(idx, data);
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_threshold();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return '0;
      if (pick < 20) return '1;
      return CSR_DATA_W'($urandom_range(100, 900));
   endfunction

   // Sets up one random phase: a fresh register setting, extremes included,
   // and one of the four patterns of idling on the two channels.
   task automatic start_phase(input int phase);
      int unsigned pick;
      logic [CSR_DATA_W-1:0] limit;
      logic [CSR_DATA_W-1:0] hold;
      write_reg(CSR_THRESHOLD_DOWN, random_threshold());
      write_reg(CSR_THRESHOLD_UP, random_threshold());
      write_reg(CSR_THRESHOLD_MID, random_threshold());
      pick = $urandom_range(0, 99);
      limit = (pick < 10) ? 10'd0 : (pick < 20) ? 10'd255
                                                : CSR_DATA_W'($urandom_range(1, 12));
      // The upper data bits do not belong to the register and must be lost.
      limit[CSR_DATA_W-1:COUNT_W] = 2'($urandom_range(0, 3));
      write_reg(CSR_TRIP_COUNT_LIMIT, limit);
      pick = $urandom_range(0, 99);
      hold = (pick < 10) ? 10'd0 : (pick < 15) ? 10'd255
                                               : CSR_DATA_W'($urandom_range(1, 15));
      write_reg(CSR_HOLD_COUNT, hold);
      write_reg(CSR_PROTECTION_ENABLE,
                (phase % 4 == 2) ? CSR_DATA_W'($urandom_range(0, 1)) : 10'd1);
      case (phase % 4)
         0: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 64;
            rsp_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            rsp_stall_pct = 64;
         end
         default: begin
            send_idle_pct = 10;
            rsp_stall_pct = 10;
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= PRINT_CAP) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         end
      end
   endtask

   // Response side. The receiver mostly stalls at random, but on request it
   // holds off for a long stretch so that both registers of the block fill
   // and the block has to push back on its input.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Every status transfer is matched against the oldest status owed.
   always @(posedge clock) begin
      ohm_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_status.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP) begin
               $display("%0t: status transfer expected none, actual fault %0d channel %0d",
                        $time, rsp_ch.fault, rsp_ch.sample_channel);
            end
         end else begin
            want = pending_status.pop_front();
            compare_field("start_held", 8'(want.start_held), 8'(rsp_ch.start_held));
            compare_field("measure_held", 8'(want.measure_held), 8'(rsp_ch.measure_held));
            compare_field("fault", 8'(want.fault), 8'(rsp_ch.fault));
            compare_field("fault_channel", 8'(want.fault_channel),
                          8'(rsp_ch.fault_channel));
            compare_field("sample_channel", 8'(want.sample_channel),
                          8'(rsp_ch.sample_channel));
         end
      end
   end

   // The whole run must finish well inside this bound.
   initial begin
      #(RUN_LIMIT);
      $display("overcurrent_and_button_hold_monitor: mismatch");
      $finish;
   end

   initial begin
      int phase;
      int n;
      int target;
      ending_type ending;
      ohm_item_type it;
      script_row_type row;

      req_ch.valid = 1'b0;
      req_ch.current_sample = '0;
      req_ch.start_button = 1'b0;
      req_ch.measure_button = 1'b0;
      req_ch.stop_button = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      clear_monitor();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed script. Right after reset all thresholds sit at full scale,
      // so no sample can be an overcurrent, and the first few status words
      // only show the channel walking around and the buttons counting.
      tick_row(10'd1023, 0, 0, 0, 1, '{0, 0, FAULT_NONE, 0, 1});
      tick_row(10'd0, 1, 1, 1, 1, '{0, 0, FAULT_NONE, 0, 2});
      tick_row(10'd512, 0, 0, 0, 1, '{0, 0, FAULT_NONE, 0, 0});
      // A hold count of zero reads every button as held, pressed or not.
      // The upper data bits fall outside the register.
      write_row(CSR_HOLD_COUNT, 10'h300);
      tick_row(10'd700, 1, 0, 0, 1, '{1, 1, FAULT_NONE, 0, 1});
      write_row(CSR_HOLD_COUNT, 10'd2);
      tick_row(10'd1, 1, 0, 0, 1, '{0, 0, FAULT_NONE, 0, 2});
      tick_row(10'd1022, 1, 1, 1, 1, '{1, 0, FAULT_NONE, 0, 0});
      tick_row(10'd300, 1, 1, 1, 1, '{1, 1, FAULT_NONE, 0, 1});
      // Lowering the hold count below a running counter keeps it held.
      write_row(CSR_HOLD_COUNT, 10'd1);
      tick_row(10'd4, 1, 1, 0, 1, '{1, 1, FAULT_NONE, 0, 2});
      tick_row(10'd8, 0, 0, 0, 1, '{0, 0, FAULT_NONE, 0, 0});
      // Alternating bit patterns for the down and up thresholds, zero for the
      // middle one; a limit of one lets a single overcurrent sample through per channel.
      write_row(CSR_THRESHOLD_DOWN, 10'h155);
      write_row(CSR_THRESHOLD_UP, 10'h2AA);
      write_row(CSR_THRESHOLD_MID, 10'h000);
      write_row(CSR_TRIP_COUNT_LIMIT, 10'd1);
      tick_row(10'h156, 0, 1, 0);
      tick_row(10'h2AA, 0, 0, 0);
      tick_row(10'h001, 0, 0, 1);
      // A sample equal to the threshold is normal and clears the run.
      tick_row(10'h155, 1, 0, 0);
      tick_row(10'h3FF, 1, 1, 0);
      tick_row(10'h000, 0, 1, 0);
      tick_row(10'h3FF, 0, 0, 0);
      tick_row(10'h2AA, 1, 0, 0);
      // With protection off the channel stands still and nothing is compared.
      write_row(CSR_PROTECTION_ENABLE, 10'd0);
      tick_row(10'h3FF, 0, 0, 0);
      tick_row(10'h3FF, 1, 0, 0);
      write_row(CSR_PROTECTION_ENABLE, 10'd1);
      write_row(CSR_SPARE_LO, 10'h3FF);
      write_row(CSR_SPARE_HI, 10'h000);
      tick_row(10'h3FF, 0, 1, 0);

      foreach (script[i]) begin
         row = script[i];
         if (row.is_write) write_reg(row.reg_index, row.reg_data);
         else send_tick(row.tick, row.has_status, row.status);
      end

      // Random phases. The first one runs without idling and carries the
      // long hold-off on the response side.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         start_phase(phase);
         for (n = 0; n < TICKS_PER_PHASE; n++) begin
            if (n % 25 == 0) begin
               hot_channels = CHANNELS'($urandom_range(0, (1 << CHANNELS) - 1));
               held_buttons = BUTTON_COUNT'($urandom_range(0, (1 << BUTTON_COUNT) - 1));
            end
            if (phase == 0 && n == 30) hold_off_request = 1'b1;
            send_tick(shaped_tick());
         end
      end

      // Ending: latch one fault on purpose, then check that the status
      // stays frozen whatever comes in.
      send_idle_pct = 10;
      rsp_stall_pct = 10;
      ending = ending_type'($urandom_range(0, 3));
      if (ending == END_TRIP_AT_ONCE || ending == END_TRIP_AFTER_RUN) begin
         target = int'($urandom_range(0, CHANNELS - 1));
         write_reg(CSR_THRESHOLD_DOWN, (target == 0) ? 10'd500 : 10'd1023);
         write_reg(CSR_THRESHOLD_UP, (target == 1) ? 10'd500 : 10'd1023);
         write_reg(CSR_THRESHOLD_MID, (target == 2) ? 10'd500 : 10'd1023);
         write_reg(CSR_TRIP_COUNT_LIMIT, (ending == END_TRIP_AT_ONCE) ? 10'd0 : 10'd2);
         write_reg(CSR_PROTECTION_ENABLE, 10'd1);
         for (n = 0; n < 64 && mon_fault == FAULT_NONE; n++) begin
            it = shaped_tick();
            it.current_sample = '1;
            send_tick(it);
         end
      end else begin
         write_reg(CSR_THRESHOLD_DOWN, 10'd1023);
         write_reg(CSR_THRESHOLD_UP, 10'd1023);
         write_reg(CSR_THRESHOLD_MID, 10'd1023);
         write_reg(CSR_HOLD_COUNT, (ending == END_STOP_AT_ONCE) ? 10'd0 : 10'd3);
         write_reg(CSR_PROTECTION_ENABLE, CSR_DATA_W'($urandom_range(0, 1)));
         for (n = 0; n < 64 && mon_fault == FAULT_NONE; n++) begin
            it = $bits(ohm_item_type)'($urandom);
            it.stop_button = 1'b1;
            send_tick(it);
         end
      end
      for (n = 0; n < 20; n++) begin
         it = $bits(ohm_item_type)'($urandom);
         send_tick(it);
      end
      // Writes after the fault are still stored.
      write_reg(CSR_HOLD_COUNT, CSR_DATA_W'($urandom_range(0, 255)));
      write_reg(CSR_THRESHOLD_MID, CSR_DATA_W'($urandom_range(0, 1023)));
      for (n = 0; n < 12; n++) begin
         it = $bits(ohm_item_type)'($urandom);
         send_tick(it);
      end

      drain_block();
      if (mismatch_count == 0 && pending_status.size() == 0) begin
         $display("overcurrent_and_button_hold_monitor: match");
      end else begin
         $display("overcurrent_and_button_hold_monitor: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
